[rtl/core/sfps_pkg.sv]
`default_nettype none

package sfps_pkg;

  // Fixed loop constants
  localparam logic [9:0]  POSITION_MAX    = 10'd640;
  localparam logic [9:0]  POSITION_CENTER = 10'd320;
  localparam logic [11:0] PULSE_MIN       = 12'd700;
  localparam logic [11:0] PULSE_MAX       = 12'd2400;
  localparam logic [16:0] ALPHA_ONE       = 17'd65536;

  // Register reset values
  localparam logic [9:0]  TARGET_RST = 10'd320;
  localparam logic [23:0] KP_RST     = 24'd19661;
  localparam logic [23:0] KI_RST     = 24'd236223;
  localparam logic [23:0] KD_RST     = 24'd595782;
  localparam logic [16:0] ALPHA_RST  = 17'd3277;
  localparam logic [9:0]  SPIKE_RST  = 10'd350;
  localparam logic [9:0]  JUMP_RST   = 10'd500;
  localparam logic [11:0] CENTER_RST = 12'd1600;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_PROP   = 3'd1,
    REG_INTEG  = 3'd2,
    REG_DERIV  = 3'd3,
    REG_ALPHA  = 3'd4,
    REG_SPIKE  = 3'd5,
    REG_JUMP   = 3'd6,
    REG_CENTER = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_IDLE     = 2'd0,
    ACT_NO_BALL  = 2'd1,
    ACT_POSITION = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MA_ALPHA,
    MA_INTEG,
    MA_PROP,
    MA_DERIV
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_EMA_DIFF,
    MB_SUM_LO,
    MB_SUM_HI,
    MB_ERR,
    MB_ERR_DIFF
  } mul_b_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_SHR16,
    ACC_ADD_SHL8,
    ACC_ADD,
    ACC_ROUND
  } acc_op_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILTER,
    OP_EMA_WB,
    OP_ERR,
    OP_PERR,
    OP_PULSE
  } dp_op_e;

  typedef enum logic {
    JC_NONE,
    JC_NOBALL
  } jmp_cond_e;

  // One control word per step
  typedef struct packed {
    logic      mul_en;
    mul_a_e    mul_a;
    mul_b_e    mul_b;
    acc_op_e   acc_op;
    dp_op_e    op;
    jmp_cond_e jc;
    step_t     jmp_tgt;
    logic      fin;
  } ucw_t;

  localparam step_t STEP_FILTER = 4'd0;
  localparam step_t STEP_EMA_MUL = 4'd1;
  localparam step_t STEP_EMA_WB = 4'd2;
  localparam step_t STEP_ERR = 4'd3;
  localparam step_t STEP_I_LO = 4'd4;
  localparam step_t STEP_I_HI = 4'd5;
  localparam step_t STEP_P_MUL = 4'd6;
  localparam step_t STEP_D_MUL = 4'd7;
  localparam step_t STEP_D_ACC = 4'd8;
  localparam step_t STEP_ROUND = 4'd9;
  localparam step_t STEP_PULSE = 4'd10;
  localparam step_t STEP_END = 4'd11;

  function automatic ucw_t ucode_rom(step_t step);
    ucw_t w;
    w = '{mul_en: 1'b0, mul_a: MA_ALPHA, mul_b: MB_EMA_DIFF, acc_op: ACC_HOLD,
          op: OP_NONE, jc: JC_NONE, jmp_tgt: STEP_FILTER, fin: 1'b0};
    unique case (step)
      STEP_FILTER: begin
        w.op      = OP_FILTER;
        w.jc      = JC_NOBALL;
        w.jmp_tgt = STEP_END;
      end
      STEP_EMA_MUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_ALPHA;
        w.mul_b  = MB_EMA_DIFF;
      end
      STEP_EMA_WB: w.op = OP_EMA_WB;
      STEP_ERR:    w.op = OP_ERR;
      STEP_I_LO: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_INTEG;
        w.mul_b  = MB_SUM_LO;
      end
      STEP_I_HI: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_INTEG;
        w.mul_b  = MB_SUM_HI;
        w.acc_op = ACC_LOAD_SHR16;
      end
      STEP_P_MUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_PROP;
        w.mul_b  = MB_ERR;
        w.acc_op = ACC_ADD_SHL8;
      end
      STEP_D_MUL: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_DERIV;
        w.mul_b  = MB_ERR_DIFF;
        w.acc_op = ACC_ADD;
      end
      STEP_D_ACC: begin
        w.acc_op = ACC_ADD;
        w.op     = OP_PERR;
      end
      STEP_ROUND: w.acc_op = ACC_ROUND;
      STEP_PULSE: w.op = OP_PULSE;
      STEP_END:   w.fin = 1'b1;
      default:    w.fin = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/spike_filtered_pid_servo.sv]
`default_nettype none

// Channel  | Dir | Handshake                | Payload
// ---------+-----+--------------------------+------------------------------------------
// input    | in  | s_tvalid / s_tready      | s_tdata: position; s_tuser: action
// result   | out | m_tvalid / m_tready      | m_tdata: pulse_width, filtered_position;
//          |     |                          | m_tuser: ball_seen, spike_rejected
// config   | in  | psel, penable, pwrite    | paddr word index, pwdata; prdata readback
//
// A position or idle beat runs from accept to result through a microcoded
// sequence of twelve steps around one shared 25x30 multiplier (EMA, two integral
// partial products, P and D terms) plus rounding and clamping.
// A no-ball beat is shorter: its filter step jumps straight to the end step.
// s_tready is high whenever no beat is in flight; a finished result waits in the
// output register, and the end step holds while that register is still full.
// Reset (rst_ni low, async) loads register defaults and centers the loop state.

module spike_filtered_pid_servo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // position [9:0], zero pad [15:10]
  input  wire logic [15:0] s_tdata,
  // action [1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pulse_width [11:0], filtered_position [21:12], zero pad [23:22]
  output logic [23:0]      m_tdata,
  // ball_seen [0], spike_rejected [1]
  output logic [1:0]       m_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------- registers
  logic [9:0]  target_q;
  logic [23:0] kp_q, ki_q, kd_q;
  logic [16:0] alpha_q;
  logic [9:0]  spike_lim_q, jump_lim_q;
  logic [11:0] center_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= sfps_pkg::TARGET_RST;
      kp_q        <= sfps_pkg::KP_RST;
      ki_q        <= sfps_pkg::KI_RST;
      kd_q        <= sfps_pkg::KD_RST;
      alpha_q     <= sfps_pkg::ALPHA_RST;
      spike_lim_q <= sfps_pkg::SPIKE_RST;
      jump_lim_q  <= sfps_pkg::JUMP_RST;
      center_q    <= sfps_pkg::CENTER_RST;
    end else if (cfg_wr) begin
      unique case (sfps_pkg::reg_idx_e'(paddr[4:2]))
        sfps_pkg::REG_TARGET: target_q    <= pwdata[9:0];
        sfps_pkg::REG_PROP:   kp_q        <= pwdata[23:0];
        sfps_pkg::REG_INTEG:  ki_q        <= pwdata[23:0];
        sfps_pkg::REG_DERIV:  kd_q        <= pwdata[23:0];
        sfps_pkg::REG_ALPHA:  alpha_q     <= pwdata[16:0];
        sfps_pkg::REG_SPIKE:  spike_lim_q <= pwdata[9:0];
        sfps_pkg::REG_JUMP:   jump_lim_q  <= pwdata[9:0];
        sfps_pkg::REG_CENTER: center_q    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sfps_pkg::reg_idx_e'(paddr[4:2]))
      sfps_pkg::REG_TARGET: prdata = {22'd0, target_q};
      sfps_pkg::REG_PROP:   prdata = {8'd0, kp_q};
      sfps_pkg::REG_INTEG:  prdata = {8'd0, ki_q};
      sfps_pkg::REG_DERIV:  prdata = {8'd0, kd_q};
      sfps_pkg::REG_ALPHA:  prdata = {15'd0, alpha_q};
      sfps_pkg::REG_SPIKE:  prdata = {22'd0, spike_lim_q};
      sfps_pkg::REG_JUMP:   prdata = {22'd0, jump_lim_q};
      sfps_pkg::REG_CENTER: prdata = {20'd0, center_q};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  logic                busy_q;
  sfps_pkg::step_t     step_q;
  logic [1:0]          action_q;
  logic [9:0]          pos_q;
  sfps_pkg::ucw_t      ucw;
  logic                noball;
  logic                in_acc;
  logic                out_load;
  logic                m_tvalid_q;

  assign ucw      = sfps_pkg::ucode_rom(step_q);
  assign noball   = (action_q == sfps_pkg::ACT_NO_BALL);
  assign s_tready = !busy_q;
  assign in_acc   = s_tvalid && !busy_q;
  // Move the result out only when the output register is free or draining
  assign out_load = busy_q && ucw.fin && (!m_tvalid_q || m_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= sfps_pkg::STEP_FILTER;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      step_q <= sfps_pkg::STEP_FILTER;
    end else if (busy_q) begin
      if (ucw.fin) begin
        if (out_load) busy_q <= 1'b0;
      end else if (ucw.jc == sfps_pkg::JC_NOBALL && noball) begin
        step_q <= ucw.jmp_tgt;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= s_tuser;
      pos_q    <= s_tdata[9:0];
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [9:0]         last_q, older_q, cand_q;
  logic [25:0]        s_q;
  logic signed [47:0] esum_q;
  logic signed [27:0] perr_q, err_q;
  logic signed [54:0] prod_q;
  logic signed [63:0] acc_q;
  logic [11:0]        pulse_q;
  logic               ball_q, rej_q;

  // spike filter
  logic [9:0]  cand_new, diff_old, diff_last;
  logic        filt_ok;

  assign cand_new  = (action_q == sfps_pkg::ACT_POSITION && pos_q <= sfps_pkg::POSITION_MAX)
                     ? pos_q : last_q;
  assign diff_old  = (cand_new > older_q) ? cand_new - older_q : older_q - cand_new;
  assign diff_last = (cand_new > last_q) ? cand_new - last_q : last_q - cand_new;
  assign filt_ok   = (diff_old < jump_lim_q) && (diff_last < spike_lim_q);

  // EMA and error terms
  logic [16:0]        alpha_lim;
  logic signed [27:0] ema_diff, err_new;
  logic signed [28:0] err_diff;
  logic signed [54:0] ema_step;
  logic [48:0]        esum_sum;
  logic signed [47:0] esum_sat;

  assign alpha_lim = (alpha_q > sfps_pkg::ALPHA_ONE) ? sfps_pkg::ALPHA_ONE : alpha_q;
  assign ema_diff  = $signed({2'b00, cand_q, 16'd0}) - $signed({2'b00, s_q});
  assign ema_step  = (prod_q + 55'sd32768) >>> 16;
  assign err_new   = $signed({2'b00, target_q, 16'd0}) - $signed({2'b00, s_q});
  assign err_diff  = $signed({err_q[27], err_q}) - $signed({perr_q[27], perr_q});
  assign esum_sum  = {esum_q[47], esum_q} + {{21{err_new[27]}}, err_new};

  always_comb begin
    if (esum_sum[48] != esum_sum[47]) begin
      // Clip to the signed 48-bit range
      esum_sat = esum_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      esum_sat = esum_sum[47:0];
    end
  end

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [54:0] prod_d;

  always_comb begin
    case (ucw.mul_a)
      sfps_pkg::MA_ALPHA: mul_a = {8'd0, alpha_lim};
      sfps_pkg::MA_INTEG: mul_a = {1'b0, ki_q};
      sfps_pkg::MA_PROP:  mul_a = {1'b0, kp_q};
      sfps_pkg::MA_DERIV: mul_a = {1'b0, kd_q};
      default:            mul_a = '0;
    endcase
    case (ucw.mul_b)
      sfps_pkg::MB_EMA_DIFF: mul_b = {{2{ema_diff[27]}}, ema_diff};
      sfps_pkg::MB_SUM_LO:   mul_b = {6'd0, esum_q[23:0]};
      sfps_pkg::MB_SUM_HI:   mul_b = {{6{esum_q[47]}}, esum_q[47:24]};
      sfps_pkg::MB_ERR:      mul_b = {{2{err_q[27]}}, err_q};
      sfps_pkg::MB_ERR_DIFF: mul_b = {err_diff[28], err_diff};
      default:               mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (busy_q && ucw.mul_en) prod_q <= prod_d;
  end

  // accumulator
  logic signed [63:0] prod_ext;
  logic signed [54:0] prod_shr;
  logic [63:0]        acc_mag, acc_rnd;
  logic [31:0]        rnd_mag;
  logic               acc_pos;
  logic signed [63:0] acc_d;

  assign prod_ext = {{9{prod_q[54]}}, prod_q};
  assign prod_shr = prod_q >>> 16;
  assign acc_mag  = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign acc_rnd  = acc_mag + 64'h0000_0000_8000_0000;
  assign rnd_mag  = acc_rnd[63:32];
  assign acc_pos  = !acc_q[63] && (acc_q != 64'sd0);

  always_comb begin
    case (ucw.acc_op)
      sfps_pkg::ACC_LOAD_SHR16: acc_d = {{9{prod_shr[54]}}, prod_shr};
      sfps_pkg::ACC_ADD_SHL8:   acc_d = acc_q + (prod_ext <<< 8);
      sfps_pkg::ACC_ADD:        acc_d = acc_q + prod_ext;
      // Negate, round half away from zero at bit 32
      sfps_pkg::ACC_ROUND:      acc_d = acc_pos ? -$signed({32'd0, rnd_mag})
                                                :  $signed({32'd0, rnd_mag});
      default:                  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) acc_q <= acc_d;
  end

  // pulse offset and clamp
  logic signed [31:0] pulse_sum;
  logic [11:0]        pulse_clip;

  assign pulse_sum = $signed(acc_q[31:0]) + $signed({20'd0, center_q});

  always_comb begin
    if (pulse_sum < $signed({20'd0, sfps_pkg::PULSE_MIN})) begin
      pulse_clip = sfps_pkg::PULSE_MIN;
    end else if (pulse_sum > $signed({20'd0, sfps_pkg::PULSE_MAX})) begin
      pulse_clip = sfps_pkg::PULSE_MAX;
    end else begin
      pulse_clip = pulse_sum[11:0];
    end
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= sfps_pkg::POSITION_CENTER;
      older_q <= sfps_pkg::POSITION_CENTER;
      s_q     <= {sfps_pkg::POSITION_CENTER, 16'd0};
      esum_q  <= '0;
      perr_q  <= '0;
    end else if (busy_q) begin
      case (ucw.op)
        sfps_pkg::OP_FILTER: begin
          if (noball) begin
            // Recenter history and filter, clear the integrator
            last_q  <= sfps_pkg::POSITION_CENTER;
            older_q <= sfps_pkg::POSITION_CENTER;
            s_q     <= {sfps_pkg::POSITION_CENTER, 16'd0};
            esum_q  <= '0;
            perr_q  <= '0;
          end else if (filt_ok) begin
            older_q <= last_q;
            last_q  <= cand_new;
          end
        end
        sfps_pkg::OP_EMA_WB: s_q <= s_q + ema_step[25:0];
        sfps_pkg::OP_ERR:    esum_q <= esum_sat;
        sfps_pkg::OP_PERR:   perr_q <= err_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (ucw.op)
        sfps_pkg::OP_FILTER: begin
          cand_q  <= filt_ok ? cand_new : last_q;
          rej_q   <= !noball && !filt_ok;
          ball_q  <= !noball;
          pulse_q <= center_q;
        end
        sfps_pkg::OP_ERR:   err_q   <= err_new;
        sfps_pkg::OP_PULSE: pulse_q <= pulse_clip;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic [11:0] m_pulse_q;
  logic [9:0]  m_filt_q;
  logic        m_ball_q, m_rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_pulse_q <= pulse_q;
      m_filt_q  <= s_q[25:16];
      m_ball_q  <= ball_q;
      m_rej_q   <= rej_q;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = {2'b00, m_filt_q, m_pulse_q};
  assign m_tuser  = {m_rej_q, m_ball_q};

  // ---------------------------------------------------------------- checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= sfps_pkg::STEP_END)
    else $error("step counter ran past the end step");

  a_prod_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(in_acc) && (ucw.acc_op == sfps_pkg::ACC_ADD ||
     ucw.acc_op == sfps_pkg::ACC_ADD_SHL8 || ucw.acc_op == sfps_pkg::ACC_LOAD_SHR16))
    |-> ($past(busy_q) && $past(ucw.mul_en)))
    else $error("accumulator consumed a product that was not issued");

  a_smooth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_q <= {sfps_pkg::POSITION_MAX, 16'd0})
    else $error("smoothed position left the position range");

  a_history_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q <= sfps_pkg::POSITION_MAX && older_q <= sfps_pkg::POSITION_MAX)
    else $error("sample history left the position range");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(busy_q))
    else $error("result raised without a beat in flight");

endmodule

`default_nettype wire
